// ----- src/scp_pkg.sv -----
// Shared types and constants of the sine and cosine polynomial unit.
package scp_pkg;

    // One angle request.
    typedef struct packed {
        logic signed [31:0] angle;
        logic               last_in;
    } in_t;

    // One sine and cosine result.
    typedef struct packed {
        logic signed [31:0] sine;
        logic signed [31:0] cosine;
        logic               last_out;
    } out_t;

    // Control that travels beside the data in every stage.
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [1:0] quad;
    } ctl_t;

    // 1/(2*pi) as unsigned Q0.64 and pi/2 as unsigned Q2.62.
    localparam logic [63:0] INV2PI_Q64 = 64'h28BE60DB9391054A;
    localparam logic [63:0] PIO2_Q62   = 64'h6487ED5110B4611B;

    localparam int NUM_COEF = 8;

    // Even polynomial coefficients, signed Q4.60, lowest order first.
    localparam logic signed [63:0] POLY_Q60 [NUM_COEF] = '{
        64'sd1152921504606844748,
        -64'sd576460752303307800,
        64'sd48038396024299631,
        -64'sd1601279864309835,
        64'sd28594278246078,
        -64'sd317709838487,
        64'sd2404801485,
        -64'sd12775196
    };

endpackage

// ----- src/sine_cosine_polynomial_unit.sv -----
// Top level of the pipelined sine and cosine polynomial unit.
//
// Usage: present an angle request on request and raise start for one cycle.
// The request is taken at any rising edge where start is high and busy is
// low; busy stays low, so a new angle may be given in every cycle.
// Each result appears on result for exactly one cycle, marked by done,
// after its request was taken, in request order. Throughput is
// one angle per cycle, set by the fully pipelined chain: two multipliers for
// turn reduction, one argument stage, one squaring multiplier pair, seven
// Horner cells of three stages each and a rounding stage.
// The receiver cannot stall; it must take every result on its done cycle.
// Reset clears all valid flags in the pipeline, so no result emerges from
// requests that were in flight when reset was asserted.
// Results: sine and cosine with OUT_FRAC_BITS fraction bits, saturated to
// plus or minus one, and last_out copied from last_in.
module sine_cosine_polynomial_unit #(
    parameter int ANGLE_FRAC_BITS = 24,
    parameter int OUT_FRAC_BITS   = 30
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  scp_pkg::in_t  request,
    output logic          done,
    output scp_pkg::out_t result
);
    import scp_pkg::*;

    localparam int CTLW   = $bits(ctl_t);
    localparam int NCELLS = NUM_COEF - 1;

    ctl_t         ctl_in, ctl_ph, ctl_u, ctl_arg_reg, ctl_zs, ctl_zc;
    logic [127:0] prod_ph, prod_u, prod_zs, prod_zc;
    logic [63:0]  phase, u, comp;
    logic [63:0]  sarg_reg, carg_reg;
    logic [CTLW-1:0] sb_ph, sb_u, sb_zs, sb_zc;

    ctl_t        ctl_ch [NUM_COEF];
    logic [63:0] zs_ch [NUM_COEF];
    logic [63:0] zc_ch [NUM_COEF];
    logic [63:0] ps_ch [NUM_COEF];
    logic [63:0] pc_ch [NUM_COEF];

    logic        done_reg;
    out_t        result_reg;
    logic [31:0] sine_next, cosine_next;

    assign busy = 1'b0;

    // Round the Q4.60 accumulator, clamp to one, apply the quadrant sign.
    function automatic logic [31:0] finish(input logic [63:0] p, input logic negate);
        logic        neg;
        logic [63:0] mag, r;
        neg = p[63];
        mag = neg ? (~p + 64'd1) : p;
        r   = (mag + (64'd1 << (59 - OUT_FRAC_BITS))) >> (60 - OUT_FRAC_BITS);
        if (r > (64'd1 << OUT_FRAC_BITS))
        begin
            r = 64'd1 << OUT_FRAC_BITS;
        end
        if (neg != negate)
        begin
            r = 64'd0 - r;
        end
        return r[31:0];
    endfunction

    // Turn fraction: angle times 1/(2*pi).
    assign ctl_in = '{valid: start & ~busy, last: request.last_in, quad: 2'b00};

    scp_mul #(.A_SIGNED(1'b1), .SBW(CTLW)) u_mul_phase (
        .clk(clk), .rst_n(rst_n),
        .a({{32{request.angle[31]}}, request.angle}), .b(INV2PI_Q64),
        .sb_in(ctl_in), .prod(prod_ph), .sb_out(sb_ph)
    );

    assign phase = prod_ph[ANGLE_FRAC_BITS + 63 : ANGLE_FRAC_BITS];
    always_comb
    begin
        ctl_ph      = ctl_t'(sb_ph);
        ctl_ph.quad = phase[63:62];
    end

    // Local argument inside the quadrant.
    scp_mul #(.A_SIGNED(1'b0), .SBW(CTLW)) u_mul_arg (
        .clk(clk), .rst_n(rst_n),
        .a({phase[61:0], 2'b00}), .b(PIO2_Q62),
        .sb_in(ctl_ph), .prod(prod_u), .sb_out(sb_u)
    );

    assign ctl_u = ctl_t'(sb_u);
    assign u     = prod_u[127:64];
    assign comp  = PIO2_Q62 - u;

    // Pick each lane's argument by quadrant.
    always_ff @(posedge clk)
    begin
        sarg_reg <= ctl_u.quad[0] ? u : comp;
        carg_reg <= ctl_u.quad[0] ? comp : u;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_arg_reg <= '0;
        end
        else
        begin
            ctl_arg_reg <= ctl_u;
        end
    end

    // Square the arguments, Q2.62.
    scp_mul #(.A_SIGNED(1'b0), .SBW(CTLW)) u_mul_zs (
        .clk(clk), .rst_n(rst_n), .a(sarg_reg), .b(sarg_reg),
        .sb_in(ctl_arg_reg), .prod(prod_zs), .sb_out(sb_zs)
    );

    scp_mul #(.A_SIGNED(1'b0), .SBW(CTLW)) u_mul_zc (
        .clk(clk), .rst_n(rst_n), .a(carg_reg), .b(carg_reg),
        .sb_in(ctl_arg_reg), .prod(prod_zc), .sb_out(sb_zc)
    );

    assign ctl_zs = ctl_t'(sb_zs);
    assign ctl_zc = ctl_t'(sb_zc);

    // Horner chain, seeded with the highest coefficient.
    assign ctl_ch[0] = ctl_zs;
    assign zs_ch[0]  = prod_zs[125:62];
    assign zc_ch[0]  = prod_zc[125:62];
    assign ps_ch[0]  = POLY_Q60[NUM_COEF-1];
    assign pc_ch[0]  = POLY_Q60[NUM_COEF-1];

    for (genvar g = 0; g < NCELLS; g++)
    begin : g_cell
        scp_cell #(.K(NCELLS - 1 - g)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .ctl_in(ctl_ch[g]), .zs_in(zs_ch[g]), .zc_in(zc_ch[g]),
            .ps_in(ps_ch[g]), .pc_in(pc_ch[g]),
            .ctl_out(ctl_ch[g+1]), .zs_out(zs_ch[g+1]), .zc_out(zc_ch[g+1]),
            .ps_out(ps_ch[g+1]), .pc_out(pc_ch[g+1])
        );
    end

    // Rounding and sign, then the result register.
    assign sine_next   = finish(ps_ch[NCELLS], ctl_ch[NCELLS].quad[1]);
    assign cosine_next = finish(pc_ch[NCELLS],
                                ctl_ch[NCELLS].quad[1] ^ ctl_ch[NCELLS].quad[0]);

    always_ff @(posedge clk)
    begin
        result_reg.sine     <= sine_next;
        result_reg.cosine   <= cosine_next;
        result_reg.last_out <= ctl_ch[NCELLS].last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_ch[NCELLS].valid;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Both squaring lanes carry the same control.
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_zs == ctl_zc)
        else $error("squaring lanes out of step");

    // Results never exceed plus or minus one.
    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(result.sine) <= $signed(32'(64'd1 << OUT_FRAC_BITS)))
              && ($signed(result.sine) >= -$signed(32'(64'd1 << OUT_FRAC_BITS))))
        else $error("sine out of range");

    a_cosine_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(result.cosine) <= $signed(32'(64'd1 << OUT_FRAC_BITS)))
              && ($signed(result.cosine) >= -$signed(32'(64'd1 << OUT_FRAC_BITS))))
        else $error("cosine out of range");

    // A result strobe comes only from a valid final cell.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctl_ch[NCELLS].valid))
        else $error("result without request");
endmodule

// ----- src/scp_mul.sv -----
// Two-stage 64 by 64 multiplier built from four 33 by 33 partial products.
module scp_mul #(
    parameter bit A_SIGNED = 1'b0,
    parameter int SBW      = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [63:0]    a,
    input  logic [63:0]    b,
    input  logic [SBW-1:0] sb_in,
    output logic [127:0]   prod,
    output logic [SBW-1:0] sb_out
);
    logic signed [32:0]  a_hi, a_lo, b_hi, b_lo;
    logic signed [65:0]  pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [SBW-1:0]      sb1_reg, sb2_reg;
    logic [127:0]        prod_next, prod_reg;

    // Split operands; only the upper half of a may carry a sign.
    assign a_hi = {(A_SIGNED ? a[63] : 1'b0), a[63:32]};
    assign a_lo = {1'b0, a[31:0]};
    assign b_hi = {1'b0, b[63:32]};
    assign b_lo = {1'b0, b[31:0]};

    // First stage: partial products.
    always_ff @(posedge clk)
    begin
        pp_ll_reg <= a_lo * b_lo;
        pp_lh_reg <= a_lo * b_hi;
        pp_hl_reg <= a_hi * b_lo;
        pp_hh_reg <= a_hi * b_hi;
    end

    // Second stage: align and sum into the full two's complement product.
    always_comb
    begin
        prod_next = {{62{pp_ll_reg[65]}}, pp_ll_reg}
                  + ({{62{pp_lh_reg[65]}}, pp_lh_reg} << 32)
                  + ({{62{pp_hl_reg[65]}}, pp_hl_reg} << 32)
                  + ({{62{pp_hh_reg[65]}}, pp_hh_reg} << 64);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Sideband follows the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb1_reg <= '0;
            sb2_reg <= '0;
        end
        else
        begin
            sb1_reg <= sb_in;
            sb2_reg <= sb1_reg;
        end
    end

    assign prod   = prod_reg;
    assign sb_out = sb2_reg;
endmodule

// ----- src/scp_cell.sv -----
// One Horner step for both the sine and the cosine lane.
module scp_cell #(
    parameter int K = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  scp_pkg::ctl_t       ctl_in,
    input  logic [63:0]         zs_in,
    input  logic [63:0]         zc_in,
    input  logic [63:0]         ps_in,
    input  logic [63:0]         pc_in,
    output scp_pkg::ctl_t       ctl_out,
    output logic [63:0]         zs_out,
    output logic [63:0]         zc_out,
    output logic [63:0]         ps_out,
    output logic [63:0]         pc_out
);
    import scp_pkg::*;

    localparam int SBS = 64 + $bits(ctl_t);

    logic [127:0]  prod_s, prod_c;
    logic [SBS-1:0] sbs_out;
    logic [63:0]   zc_mid;
    ctl_t          ctl_reg;
    logic [63:0]   zs_reg, zc_reg, ps_reg, pc_reg;

    // p * z for each lane, with the squared argument riding along.
    scp_mul #(.A_SIGNED(1'b1), .SBW(SBS)) u_mul_s (
        .clk(clk), .rst_n(rst_n), .a(ps_in), .b(zs_in),
        .sb_in({zs_in, ctl_in}), .prod(prod_s), .sb_out(sbs_out)
    );

    scp_mul #(.A_SIGNED(1'b1), .SBW(64)) u_mul_c (
        .clk(clk), .rst_n(rst_n), .a(pc_in), .b(zc_in),
        .sb_in(zc_in), .prod(prod_c), .sb_out(zc_mid)
    );

    // Add the coefficient to the floored product, Q4.60.
    always_ff @(posedge clk)
    begin
        ps_reg <= POLY_Q60[K] + prod_s[125:62];
        pc_reg <= POLY_Q60[K] + prod_c[125:62];
        zs_reg <= sbs_out[SBS-1 -: 64];
        zc_reg <= zc_mid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_t'(sbs_out[$bits(ctl_t)-1:0]);
        end
    end

    assign ctl_out = ctl_reg;
    assign zs_out  = zs_reg;
    assign zc_out  = zc_reg;
    assign ps_out  = ps_reg;
    assign pc_out  = pc_reg;
endmodule
